FILE: rtl/ihp_pkg.sv
// Shared types, constants and codes for the indexed min-heap.
`timescale 1ns / 1ps
package ihp_pkg;

  localparam int NODE_W       = 10;
  localparam int NODE_SPACE   = 1024;
  localparam int IN_KEY_W     = 32;
  localparam int STATUS_W     = 3;
  localparam int COUNT_OUT_W  = 11;
  localparam int CAPACITY_DEF = 1024;
  localparam int KEY_BITS_DEF = 32;

  localparam logic OP_UPDATE  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DECREASED = 3'd1,
    ST_IGNORED   = 3'd2,
    ST_FULL      = 3'd3,
    ST_EXTRACTED = 3'd4,
    ST_EMPTY     = 3'd5
  } status_e;

  // Datapath step selected by the controller each cycle
  typedef enum logic [4:0] {
    DP_IDLE,
    DP_CLEAR,
    DP_LOAD,
    DP_LOOK,
    DP_LOOK2,
    DP_UP0,
    DP_UP1,
    DP_UP2,
    DP_PLACE,
    DP_EXT0,
    DP_EXT1,
    DP_EXT2,
    DP_EXT3,
    DP_DN0,
    DP_DN1,
    DP_DN2,
    DP_DN3,
    DP_DN4
  } dp_step_e;

  typedef struct packed {
    dp_step_e step;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic absent;
    logic full;
    logic lower;
    logic at_root;
    logic count_zero;
    logic no_child;
    logic has_right;
    logic up_lt;
    logic move_gt;
  } sts_t;

endpackage

FILE: rtl/ihp_datapath.sv
// Heap memories, working registers and result register of the indexed min-heap.
`timescale 1ns / 1ps
module ihp_datapath
  import ihp_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  input  logic [NODE_W-1:0]      node_id_i,
  input  logic [IN_KEY_W-1:0]    new_key_i,
  output logic [STATUS_W-1:0]    status_o,
  output logic [NODE_W-1:0]      out_id_o,
  output logic [IN_KEY_W-1:0]    out_key_o,
  output logic [COUNT_OUT_W-1:0] heap_count_o
);

  localparam int SLOT_W = $clog2(CAPACITY + 1);
  localparam int SA_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Memories
  logic [NODE_W-1:0]   sn_mem [CAPACITY];
  logic [SLOT_W-1:0]   ns_mem [NODE_SPACE];
  logic [KEY_BITS-1:0] nk_mem [NODE_SPACE];

  logic [NODE_W-1:0]   sn_rd;
  logic [SLOT_W-1:0]   ns_rd;
  logic [KEY_BITS-1:0] nk_rd;

  // Working registers
  logic [NODE_W-1:0]   id_q, m_q, pid_q, cl_q, cr_q, nc_q, oid_q, clr_q;
  logic [KEY_BITS-1:0] key_q, k_q, kl_q, kc_q, okey_q;
  logic [SLOT_W-1:0]   count_q, s_q, cs_q;
  status_e             status_q;

  logic [STATUS_W-1:0]    res_status_q;
  logic [NODE_W-1:0]      res_id_q;
  logic [IN_KEY_W-1:0]    res_key_q;
  logic [COUNT_OUT_W-1:0] res_count_q;

  // Derived slot arithmetic
  logic [SLOT_W-1:0]   par, par_m1, s_m1, cnt_m1, c_lo, c_hi;
  logic [SLOT_W:0]     c_full;
  logic [KEY_BITS+IN_KEY_W-1:0]     key_wide;
  logic [KEY_BITS+IN_KEY_W-1:0]     okey_wide;
  logic [SLOT_W+COUNT_OUT_W-1:0]    cnt_wide;

  assign par    = s_q >> 1;
  assign par_m1 = par - SLOT_W'(1);
  assign s_m1   = s_q - SLOT_W'(1);
  assign cnt_m1 = count_q - SLOT_W'(1);
  assign c_full = {s_q, 1'b0};
  assign c_lo   = c_full[SLOT_W-1:0];
  assign c_hi   = c_lo + SLOT_W'(1);
  assign key_wide  = {{KEY_BITS{1'b0}}, new_key_i};
  assign okey_wide = {{IN_KEY_W{1'b0}}, okey_q};
  assign cnt_wide  = {{COUNT_OUT_W{1'b0}}, count_q};

  // Memory ports
  logic [SA_W-1:0]     sn_ra, sn_wa;
  logic                sn_we, ns_we, nk_we;
  logic [NODE_W-1:0]   sn_wd, ns_wa, nk_ra;
  logic [SLOT_W-1:0]   ns_wd;
  logic [SLOT_W-1:0]   sn_ra_full;

  always_comb begin
    sn_ra_full = par_m1;
    nk_ra      = sn_rd;
    sn_we      = 1'b0;
    ns_we      = 1'b0;
    nk_we      = 1'b0;
    sn_wd      = m_q;
    ns_wa      = m_q;
    ns_wd      = s_q;
    case (cmd_i.step)
      DP_CLEAR: begin
        ns_we = 1'b1;
        ns_wa = clr_q;
        ns_wd = '0;
      end
      DP_LOOK:  nk_ra = id_q;
      DP_LOOK2: nk_we = ns_rd == '0 ? (count_q != SLOT_W'(CAPACITY)) : (key_q < nk_rd);
      DP_UP0:   sn_ra_full = par_m1;
      DP_UP2: begin
        if (k_q < nk_rd) begin
          sn_we = 1'b1;
          sn_wd = pid_q;
          ns_we = 1'b1;
          ns_wa = pid_q;
        end
      end
      DP_PLACE: begin
        sn_we = 1'b1;
        ns_we = 1'b1;
      end
      DP_EXT0:  sn_ra_full = '0;
      DP_EXT1:  sn_ra_full = cnt_m1;
      DP_EXT2: begin
        ns_we = 1'b1;
        ns_wa = oid_q;
        ns_wd = '0;
      end
      DP_DN0:   sn_ra_full = c_lo - SLOT_W'(1);
      DP_DN1:   sn_ra_full = c_lo;
      DP_DN4: begin
        if (k_q > kc_q) begin
          sn_we = 1'b1;
          sn_wd = nc_q;
          ns_we = 1'b1;
          ns_wa = nc_q;
        end
      end
      default: ;
    endcase
  end

  assign sn_ra = sn_ra_full[SA_W-1:0];
  assign sn_wa = s_m1[SA_W-1:0];

  always_ff @(posedge clk_i) begin
    if (sn_we) sn_mem[sn_wa] <= sn_wd;
    sn_rd <= sn_mem[sn_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ns_we) ns_mem[ns_wa] <= ns_wd;
    ns_rd <= ns_mem[id_q];
  end

  always_ff @(posedge clk_i) begin
    if (nk_we) nk_mem[id_q] <= key_q;
    nk_rd <= nk_mem[nk_ra];
  end

  // Control registers: count and clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      clr_q   <= '0;
    end else begin
      if (cmd_i.step == DP_CLEAR) clr_q <= clr_q + NODE_W'(1);
      if (cmd_i.step == DP_LOOK2 && ns_rd == '0 && count_q != SLOT_W'(CAPACITY)) begin
        count_q <= count_q + SLOT_W'(1);
      end
      if (cmd_i.step == DP_EXT2) count_q <= cnt_m1;
    end
  end

  // Working registers per step
  always_ff @(posedge clk_i) begin
    case (cmd_i.step)
      DP_LOAD: begin
        id_q  <= node_id_i;
        key_q <= key_wide[KEY_BITS-1:0];
      end
      DP_LOOK2: begin
        oid_q <= id_q;
        m_q   <= id_q;
        k_q   <= key_q;
        if (ns_rd == '0) begin
          s_q <= count_q + SLOT_W'(1);
          if (count_q == SLOT_W'(CAPACITY)) begin
            status_q <= ST_FULL;
            okey_q   <= '0;
          end else begin
            status_q <= ST_INSERTED;
            okey_q   <= key_q;
          end
        end else begin
          s_q <= ns_rd;
          if (key_q < nk_rd) begin
            status_q <= ST_DECREASED;
            okey_q   <= key_q;
          end else begin
            status_q <= ST_IGNORED;
            okey_q   <= nk_rd;
          end
        end
      end
      DP_UP1: pid_q <= sn_rd;
      DP_UP2: if (k_q < nk_rd) s_q <= par;
      DP_EXT0: begin
        status_q <= ST_EMPTY;
        oid_q    <= '0;
        okey_q   <= '0;
      end
      DP_EXT1: oid_q <= sn_rd;
      DP_EXT2: begin
        okey_q   <= nk_rd;
        m_q      <= sn_rd;
        status_q <= ST_EXTRACTED;
      end
      DP_EXT3: begin
        k_q <= nk_rd;
        s_q <= SLOT_W'(1);
      end
      DP_DN1: cl_q <= sn_rd;
      DP_DN2: begin
        kl_q <= nk_rd;
        cr_q <= sn_rd;
        nc_q <= cl_q;
        kc_q <= nk_rd;
        cs_q <= c_lo;
      end
      DP_DN3: begin
        if (nk_rd < kl_q) begin
          nc_q <= cr_q;
          kc_q <= nk_rd;
          cs_q <= c_hi;
        end
      end
      DP_DN4: if (k_q > kc_q) s_q <= cs_q;
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_status_q <= status_q;
      res_id_q     <= oid_q;
      res_key_q    <= okey_wide[IN_KEY_W-1:0];
      res_count_q  <= cnt_wide[COUNT_OUT_W-1:0];
    end
  end

  assign status_o     = res_status_q;
  assign out_id_o     = res_id_q;
  assign out_key_o    = res_key_q;
  assign heap_count_o = res_count_q;

  // Status toward the controller
  always_comb begin
    sts_o.clr_last   = &clr_q;
    sts_o.absent     = ns_rd == '0;
    sts_o.full       = count_q == SLOT_W'(CAPACITY);
    sts_o.lower      = key_q < nk_rd;
    sts_o.at_root    = s_q == SLOT_W'(1);
    sts_o.count_zero = count_q == '0;
    sts_o.no_child   = c_full > {1'b0, count_q};
    sts_o.has_right  = c_full < {1'b0, count_q};
    sts_o.up_lt      = k_q < nk_rd;
    sts_o.move_gt    = k_q > kc_q;
  end

endmodule

FILE: rtl/ihp_ctrl.sv
// Sequencing state machine of the indexed min-heap.
`timescale 1ns / 1ps
module ihp_ctrl
  import ihp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic operation_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_LOOK  = 5'd2;
  localparam logic [4:0] S_LOOK2 = 5'd3;
  localparam logic [4:0] S_UP0   = 5'd4;
  localparam logic [4:0] S_UP1   = 5'd5;
  localparam logic [4:0] S_UP2   = 5'd6;
  localparam logic [4:0] S_PLACE = 5'd7;
  localparam logic [4:0] S_EXT0  = 5'd8;
  localparam logic [4:0] S_EXT1  = 5'd9;
  localparam logic [4:0] S_EXT2  = 5'd10;
  localparam logic [4:0] S_EXT3  = 5'd11;
  localparam logic [4:0] S_DN0   = 5'd12;
  localparam logic [4:0] S_DN1   = 5'd13;
  localparam logic [4:0] S_DN2   = 5'd14;
  localparam logic [4:0] S_DN3   = 5'd15;
  localparam logic [4:0] S_DN4   = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  logic [4:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // Next state and datapath command
  always_comb begin
    state_d      = state_q;
    cmd_o.step   = DP_IDLE;
    cmd_o.out_load = 1'b0;
    in_ready_o   = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.step = DP_CLEAR;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.step = DP_LOAD;
          state_d    = (operation_i == OP_EXTRACT) ? S_EXT0 : S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.step = DP_LOOK;
        state_d    = S_LOOK2;
      end
      S_LOOK2: begin
        cmd_o.step = DP_LOOK2;
        if (sts_i.absent ? sts_i.full : !sts_i.lower) state_d = S_DONE;
        else state_d = S_UP0;
      end
      S_UP0: begin
        cmd_o.step = DP_UP0;
        state_d    = sts_i.at_root ? S_PLACE : S_UP1;
      end
      S_UP1: begin
        cmd_o.step = DP_UP1;
        state_d    = S_UP2;
      end
      S_UP2: begin
        cmd_o.step = DP_UP2;
        state_d    = sts_i.up_lt ? S_UP0 : S_PLACE;
      end
      S_PLACE: begin
        cmd_o.step = DP_PLACE;
        state_d    = S_DONE;
      end
      S_EXT0: begin
        cmd_o.step = DP_EXT0;
        state_d    = sts_i.count_zero ? S_DONE : S_EXT1;
      end
      S_EXT1: begin
        cmd_o.step = DP_EXT1;
        state_d    = S_EXT2;
      end
      S_EXT2: begin
        cmd_o.step = DP_EXT2;
        state_d    = S_EXT3;
      end
      S_EXT3: begin
        cmd_o.step = DP_EXT3;
        state_d    = sts_i.count_zero ? S_DONE : S_DN0;
      end
      S_DN0: begin
        cmd_o.step = DP_DN0;
        state_d    = sts_i.no_child ? S_PLACE : S_DN1;
      end
      S_DN1: begin
        cmd_o.step = DP_DN1;
        state_d    = S_DN2;
      end
      S_DN2: begin
        cmd_o.step = DP_DN2;
        state_d    = sts_i.has_right ? S_DN3 : S_DN4;
      end
      S_DN3: begin
        cmd_o.step = DP_DN3;
        state_d    = S_DN4;
      end
      S_DN4: begin
        cmd_o.step = DP_DN4;
        state_d    = sts_i.move_gt ? S_DN0 : S_PLACE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the result valid until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/indexed_min_heap.sv
// Top level of the indexed binary min-heap with insert, decrease-key and extract-min.
`timescale 1ns / 1ps
// Indexed min-heap of up to CAPACITY node identifiers ordered by KEY_BITS-wide
// unsigned keys. One request is worked at a time; each produces one result.
// After reset a clearing pass empties every entry of the position table, and
// no request is taken until it ends. An update first looks up the node's slot
// and key; one that is ignored or finds the heap full ends there, while an
// insert or decrease moves the node up past every parent with a larger key and
// then places it. An extract of an empty heap ends at once; otherwise it takes
// the root, and unless that empties the heap it moves the last node to the
// root and sinks it below its smaller child (the left one on a tie) while that
// child's key is smaller, then places it. Each heap memory has a single
// registered read port. The result register is loaded once no earlier result
// still waits there; that register can hold a result while the next request
// is taken.
module indexed_min_heap
  import ihp_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   operation_i,
  input  logic [NODE_W-1:0]      node_id_i,
  input  logic [IN_KEY_W-1:0]    new_key_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [STATUS_W-1:0]    status_o,
  output logic [NODE_W-1:0]      out_id_o,
  output logic [IN_KEY_W-1:0]    out_key_o,
  output logic [COUNT_OUT_W-1:0] heap_count_o
);

  cmd_t cmd;
  sts_t sts;

  ihp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ihp_datapath #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .node_id_i    (node_id_i),
    .new_key_i    (new_key_i),
    .status_o     (status_o),
    .out_id_o     (out_id_o),
    .out_key_o    (out_key_o),
    .heap_count_o (heap_count_o)
  );

endmodule
